### rtl/pdll_pkg.sv
// Shared definitions for the pooled doubly linked list engine.
// Holds the command and status codes, default sizes and the result beat type.
// No dependencies; every other file imports this package.
package pdll_pkg;

	// Default pool sizes, handed to the top-level parameters.
	localparam int DefNumLists = 16;
	localparam int DefNumNodes = 256;
	localparam int DefItemWidth = 32;

	// Command codes.
	localparam logic [3:0] CMD_CREATE  = 4'd0;
	localparam logic [3:0] CMD_COUNT   = 4'd1;
	localparam logic [3:0] CMD_FIRST   = 4'd2;
	localparam logic [3:0] CMD_LAST    = 4'd3;
	localparam logic [3:0] CMD_NEXT    = 4'd4;
	localparam logic [3:0] CMD_PREV    = 4'd5;
	localparam logic [3:0] CMD_CURRENT = 4'd6;
	localparam logic [3:0] CMD_ADD     = 4'd7;
	localparam logic [3:0] CMD_INSERT  = 4'd8;
	localparam logic [3:0] CMD_APPEND  = 4'd9;
	localparam logic [3:0] CMD_PREPEND = 4'd10;
	localparam logic [3:0] CMD_REMOVE  = 4'd11;
	localparam logic [3:0] CMD_CONCAT  = 4'd12;
	localparam logic [3:0] CMD_FREE    = 4'd13;
	localparam logic [3:0] CMD_TRIM    = 4'd14;
	localparam logic [3:0] CMD_SEARCH  = 4'd15;

	// Status codes.
	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_NULL = 2'd1;
	localparam logic [1:0] ST_EXH  = 2'd2;

	// One result beat.
	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] item;
		logic [8:0]  count;
		logic [3:0]  new_id;
	} pdll_result_t;

endpackage

### rtl/pdll_node_mem.sv
// Node storage: next links, prev links, payloads and the free node chain.
// Synchronous memories with registered reads; node reads and all writes past the pool are masked.
// Depends on pdll_pkg for default sizes.
module pdll_node_mem #(
	parameter int NUM_NODES = pdll_pkg::DefNumNodes,
	parameter int ITEM_WIDTH = pdll_pkg::DefItemWidth,
	localparam int AW = (NUM_NODES > 1) ? $clog2(NUM_NODES) : 1,
	localparam int LW = $clog2(NUM_NODES + 1),
	localparam int CW = $clog2(NUM_NODES + 2)
) (
	input  logic                  clk,
	input  logic [CW-1:0]         rd_addr,
	output logic [LW-1:0]         rd_next,
	output logic [LW-1:0]         rd_prev,
	output logic [ITEM_WIDTH-1:0] rd_item,
	input  logic                  nx_we,
	input  logic [CW-1:0]         nx_addr,
	input  logic [LW-1:0]         nx_data,
	input  logic                  pv_we,
	input  logic [CW-1:0]         pv_addr,
	input  logic [LW-1:0]         pv_data,
	input  logic                  it_we,
	input  logic [CW-1:0]         it_addr,
	input  logic [ITEM_WIDTH-1:0] it_data,
	input  logic [CW-1:0]         fc_raddr,
	output logic [LW-1:0]         fc_rd,
	input  logic                  fc_we,
	input  logic [CW-1:0]         fc_waddr,
	input  logic [LW-1:0]         fc_data
);
	import pdll_pkg::*;

	localparam logic [CW-1:0] POOL = CW'(NUM_NODES);
	localparam logic [LW-1:0] LNULL = LW'(NUM_NODES);

	logic [LW-1:0]         nx_mem [NUM_NODES];
	logic [LW-1:0]         pv_mem [NUM_NODES];
	logic [ITEM_WIDTH-1:0] it_mem [NUM_NODES];
	logic [LW-1:0]         fc_mem [NUM_NODES];
	logic                  rd_ok_q;
	logic [LW-1:0]         nx_q;
	logic [LW-1:0]         pv_q;
	logic [ITEM_WIDTH-1:0] it_q;
	logic [LW-1:0]         fc_q;

	// Registered reads; the pool check is carried along with the data.
	always_ff @(posedge clk) begin
		rd_ok_q <= rd_addr < POOL;
		nx_q <= nx_mem[rd_addr[AW-1:0]];
		pv_q <= pv_mem[rd_addr[AW-1:0]];
		it_q <= it_mem[rd_addr[AW-1:0]];
		fc_q <= fc_mem[fc_raddr[AW-1:0]];
	end

	// Writes beyond the pool are dropped.
	always_ff @(posedge clk) begin
		if (nx_we && nx_addr < POOL) nx_mem[nx_addr[AW-1:0]] <= nx_data;
		if (pv_we && pv_addr < POOL) pv_mem[pv_addr[AW-1:0]] <= pv_data;
		if (it_we && it_addr < POOL) it_mem[it_addr[AW-1:0]] <= it_data;
		if (fc_we && fc_waddr < POOL) fc_mem[fc_waddr[AW-1:0]] <= fc_data;
	end

	// A node read past the pool gives a null link and a zero payload; the free chain read is not masked.
	assign rd_next = rd_ok_q ? nx_q : LNULL;
	assign rd_prev = rd_ok_q ? pv_q : LNULL;
	assign rd_item = rd_ok_q ? it_q : '0;
	assign fc_rd = fc_q;

endmodule

### rtl/pdll_ctrl.sv
// Command sequencer: list head table, free pools and the node memory walk.
// Runs the clearing pass after reset and hands one result beat per command.
// Depends on pdll_pkg; drives the ports of pdll_node_mem.
module pdll_ctrl #(
	parameter int NUM_LISTS = pdll_pkg::DefNumLists,
	parameter int NUM_NODES = pdll_pkg::DefNumNodes,
	parameter int ITEM_WIDTH = pdll_pkg::DefItemWidth,
	localparam int LW = $clog2(NUM_NODES + 1),
	localparam int CW = $clog2(NUM_NODES + 2)
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic [3:0]              command,
	input  logic [3:0]              list_id,
	input  logic [3:0]              other_list_id,
	input  logic [31:0]             item_value,
	output logic                    res_valid,
	input  logic                    res_take,
	output pdll_pkg::pdll_result_t  res,
	output logic [CW-1:0]           rd_addr,
	input  logic [LW-1:0]           rd_next,
	input  logic [LW-1:0]           rd_prev,
	input  logic [ITEM_WIDTH-1:0]   rd_item,
	output logic                    nx_we,
	output logic [CW-1:0]           nx_addr,
	output logic [LW-1:0]           nx_data,
	output logic                    pv_we,
	output logic [CW-1:0]           pv_addr,
	output logic [LW-1:0]           pv_data,
	output logic                    it_we,
	output logic [CW-1:0]           it_addr,
	output logic [ITEM_WIDTH-1:0]   it_data,
	output logic [CW-1:0]           fc_raddr,
	input  logic [LW-1:0]           fc_rd,
	output logic                    fc_we,
	output logic [CW-1:0]           fc_waddr,
	output logic [LW-1:0]           fc_data
);
	import pdll_pkg::*;

	localparam int HW = $clog2(NUM_LISTS);
	localparam int HNW = $clog2(NUM_LISTS + 1);
	localparam logic [LW-1:0] LNULL = LW'(NUM_NODES);
	localparam logic [CW-1:0] POOL = CW'(NUM_NODES);
	localparam logic [CW-1:0] BEFORE = CW'(NUM_NODES);
	localparam logic [CW-1:0] BEYOND = CW'(NUM_NODES + 1);
	localparam logic [HNW-1:0] HPOOL = HNW'(NUM_LISTS);

	// Sequencer states.
	localparam logic [4:0] S_CLR   = 5'd0;
	localparam logic [4:0] S_IDLE  = 5'd1;
	localparam logic [4:0] S_LOAD  = 5'd2;
	localparam logic [4:0] S_EXEC  = 5'd3;
	localparam logic [4:0] S_LD2   = 5'd4;
	localparam logic [4:0] S_CAT   = 5'd5;
	localparam logic [4:0] S_MV1   = 5'd6;
	localparam logic [4:0] S_ITM   = 5'd7;
	localparam logic [4:0] S_LNK   = 5'd8;
	localparam logic [4:0] S_LNK2  = 5'd9;
	localparam logic [4:0] S_RM0   = 5'd10;
	localparam logic [4:0] S_RM1   = 5'd11;
	localparam logic [4:0] S_RM2   = 5'd12;
	localparam logic [4:0] S_SRI   = 5'd13;
	localparam logic [4:0] S_SRC   = 5'd14;
	localparam logic [4:0] S_WB    = 5'd15;
	localparam logic [4:0] S_GIVEH = 5'd16;
	localparam logic [4:0] S_OUT   = 5'd17;

	// Link placement for the four insertion commands.
	localparam logic [1:0] LK_EMPTY = 2'd0;
	localparam logic [1:0] LK_BACK  = 2'd1;
	localparam logic [1:0] LK_FRONT = 2'd2;
	localparam logic [1:0] LK_MID   = 2'd3;

	// Reduce a list id to the head pool.
	function automatic logic [HW-1:0] id_mod(input logic [3:0] v);
		logic [4:0] r;
		r = {1'b0, v};
		for (int k = 0; k < 8; k++) begin
			if (int'(r) >= NUM_LISTS) r = r - 5'(NUM_LISTS);
		end
		return HW'(r);
	endfunction

	logic [4:0]            state_q;
	logic [LW-1:0]         clr_q;
	logic [3:0]            cmd_q;
	logic [HW-1:0]         h_q;
	logic [HW-1:0]         h2_q;
	logic [ITEM_WIDTH-1:0] val_q;
	logic [LW-1:0]         f_q;
	logic [LW-1:0]         l_q;
	logic [CW-1:0]         c_q;
	logic [LW-1:0]         n_q;
	logic [LW-1:0]         f2_q;
	logic [LW-1:0]         l2_q;
	logic [LW-1:0]         n2_q;
	logic [LW-1:0]         nn_q;
	logic [LW-1:0]         o_q;
	logic [LW-1:0]         rm_q;
	logic [CW-1:0]         si_q;
	logic [1:0]            st_q;
	logic [ITEM_WIDTH-1:0] it_q;
	logic [3:0]            nid_q;

	// Free node pool and list head table.
	logic [LW-1:0]  fn_top_q;
	logic [LW-1:0]  fn_total_q;
	logic [HNW-1:0] fh_top_q;
	logic [HNW-1:0] fh_total_q;
	logic [LW-1:0]  hf_q  [NUM_LISTS];
	logic [LW-1:0]  hl_q  [NUM_LISTS];
	logic [CW-1:0]  hc_q  [NUM_LISTS];
	logic [LW-1:0]  hn_q  [NUM_LISTS];
	logic [HNW-1:0] hch_q [NUM_LISTS];

	logic [HW-1:0] hr_idx;
	logic [HW-1:0] gh_idx;
	logic          take_ok;
	logic          head_ok;
	logic [LW-1:0] t_mv;
	logic [1:0]    lk_mode;
	logic [LW-1:0] lk_o;
	logic [LW:0]   cat_sum;
	logic [LW-1:0] cat_len;
	logic          is_add;

	assign in_stall = state_q != S_IDLE;
	assign hr_idx = (state_q == S_LD2) ? h2_q : h_q;
	assign gh_idx = (cmd_q == CMD_FREE) ? h_q : h2_q;
	assign take_ok = fn_total_q != '0 && fn_top_q < LNULL;
	assign head_ok = fh_total_q != '0 && fh_top_q < HPOOL;
	assign t_mv = (cmd_q == CMD_NEXT) ? rd_next : rd_prev;
	assign is_add = cmd_q == CMD_ADD;
	assign lk_o = is_add ? rd_next : rd_prev;
	assign cat_sum = {1'b0, n_q} + {1'b0, n2_q};
	assign cat_len = (cat_sum > (LW + 1)'(NUM_NODES)) ? LNULL : cat_sum[LW-1:0];

	// Where a new node goes relative to the cursor.
	always_comb begin
		if (n_q == '0) begin
			lk_mode = LK_EMPTY;
		end else if (cmd_q == CMD_APPEND) begin
			lk_mode = LK_BACK;
		end else if (cmd_q == CMD_PREPEND) begin
			lk_mode = LK_FRONT;
		end else if (is_add) begin
			if (c_q == BEFORE) lk_mode = LK_FRONT;
			else if (c_q >= POOL || c_q == CW'(l_q)) lk_mode = LK_BACK;
			else lk_mode = LK_MID;
		end else begin
			if (c_q == BEFORE || c_q == CW'(f_q)) lk_mode = LK_FRONT;
			else if (c_q >= POOL) lk_mode = LK_BACK;
			else lk_mode = LK_MID;
		end
	end

	// Result beat; the count is read from the head table after write-back.
	assign res_valid = state_q == S_OUT;
	always_comb begin
		res.status = st_q;
		res.item = (st_q == ST_OK) ? 32'(it_q) : 32'd0;
		res.count = 9'(hn_q[h_q]);
		res.new_id = nid_q;
	end

	// Node memory port control.
	always_comb begin
		rd_addr = c_q;
		fc_raddr = CW'(fn_top_q);
		nx_we = 1'b0;
		nx_addr = c_q;
		nx_data = LNULL;
		pv_we = 1'b0;
		pv_addr = c_q;
		pv_data = LNULL;
		it_we = 1'b0;
		it_addr = c_q;
		it_data = '0;
		fc_we = 1'b0;
		fc_waddr = CW'(rm_q);
		fc_data = fn_top_q;
		unique case (state_q)
			S_CLR: begin
				nx_we = 1'b1;
				nx_addr = CW'(clr_q);
				pv_we = 1'b1;
				pv_addr = CW'(clr_q);
				it_we = 1'b1;
				it_addr = CW'(clr_q);
				fc_we = 1'b1;
				fc_waddr = CW'(clr_q);
				fc_data = clr_q + LW'(1);
			end
			S_EXEC: begin
				unique case (cmd_q)
					CMD_FIRST: rd_addr = CW'(f_q);
					CMD_LAST: rd_addr = CW'(l_q);
					CMD_NEXT: rd_addr = (c_q == BEFORE) ? CW'(f_q) : c_q;
					CMD_PREV: rd_addr = (c_q == BEYOND) ? CW'(l_q) : c_q;
					CMD_ADD, CMD_INSERT, CMD_APPEND, CMD_PREPEND: begin
						// Fresh node: payload stored, both links null.
						it_we = take_ok;
						it_addr = CW'(fn_top_q);
						it_data = val_q;
						nx_we = take_ok;
						nx_addr = CW'(fn_top_q);
						pv_we = take_ok;
						pv_addr = CW'(fn_top_q);
					end
					default: ;
				endcase
			end
			S_MV1: rd_addr = CW'(t_mv);
			S_LNK: begin
				unique case (lk_mode)
					LK_BACK: begin
						nx_we = 1'b1;
						nx_addr = CW'(l_q);
						nx_data = nn_q;
						pv_we = 1'b1;
						pv_addr = CW'(nn_q);
						pv_data = l_q;
					end
					LK_FRONT: begin
						pv_we = 1'b1;
						pv_addr = CW'(f_q);
						pv_data = nn_q;
						nx_we = 1'b1;
						nx_addr = CW'(nn_q);
						nx_data = f_q;
					end
					LK_MID: begin
						nx_we = 1'b1;
						pv_we = 1'b1;
						if (is_add) begin
							nx_addr = c_q;
							nx_data = nn_q;
							pv_addr = CW'(nn_q);
							pv_data = LW'(c_q);
						end else begin
							pv_addr = c_q;
							pv_data = nn_q;
							nx_addr = CW'(nn_q);
							nx_data = LW'(c_q);
						end
					end
					default: ;
				endcase
			end
			S_LNK2: begin
				nx_we = 1'b1;
				pv_we = 1'b1;
				if (is_add) begin
					nx_addr = CW'(nn_q);
					nx_data = o_q;
					pv_addr = CW'(o_q);
					pv_data = nn_q;
				end else begin
					pv_addr = CW'(nn_q);
					pv_data = o_q;
					nx_addr = CW'(o_q);
					nx_data = nn_q;
				end
			end
			S_RM0: rd_addr = c_q;
			S_RM1: begin
				// Unlink the node under the cursor.
				if (n_q == LW'(1)) begin
				end else if (c_q == CW'(f_q)) begin
					pv_we = 1'b1;
					pv_addr = CW'(rd_next);
				end else if (c_q == CW'(l_q)) begin
					nx_we = 1'b1;
					nx_addr = CW'(rd_prev);
				end else begin
					nx_we = 1'b1;
					nx_addr = CW'(rd_prev);
					nx_data = rd_next;
					pv_we = 1'b1;
					pv_addr = CW'(rd_next);
					pv_data = rd_prev;
				end
			end
			S_RM2: begin
				// Return the node to the free chain and scrub it.
				nx_we = 1'b1;
				nx_addr = CW'(rm_q);
				pv_we = 1'b1;
				pv_addr = CW'(rm_q);
				it_we = 1'b1;
				it_addr = CW'(rm_q);
				fc_we = 1'b1;
			end
			S_SRI: rd_addr = c_q;
			S_CAT: begin
				if (n_q != '0 && n2_q != '0) begin
					nx_we = 1'b1;
					nx_addr = CW'(l_q);
					nx_data = f2_q;
					pv_we = 1'b1;
					pv_addr = CW'(f2_q);
					pv_data = l_q;
				end
			end
			default: ;
		endcase
	end

	// Sequencer, working registers, pools and head table.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			clr_q <= '0;
			fn_top_q <= '0;
			fn_total_q <= LNULL;
			fh_top_q <= '0;
			fh_total_q <= HPOOL;
			for (int i = 0; i < NUM_LISTS; i++) begin
				hf_q[i] <= LNULL;
				hl_q[i] <= LNULL;
				hc_q[i] <= BEFORE;
				hn_q[i] <= '0;
				hch_q[i] <= HNW'(i + 1);
			end
		end else begin
			unique case (state_q)
				S_CLR: begin
					clr_q <= clr_q + LW'(1);
					if (clr_q == LW'(NUM_NODES - 1)) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (in_valid) begin
						cmd_q <= command;
						h_q <= id_mod(list_id);
						h2_q <= id_mod(other_list_id);
						val_q <= ITEM_WIDTH'(item_value);
						st_q <= ST_OK;
						it_q <= '0;
						nid_q <= '0;
						state_q <= S_LOAD;
					end
				end
				S_LOAD: begin
					f_q <= hf_q[hr_idx];
					l_q <= hl_q[hr_idx];
					c_q <= hc_q[hr_idx];
					n_q <= hn_q[hr_idx];
					state_q <= S_EXEC;
				end
				S_EXEC: begin
					unique case (cmd_q)
						CMD_CREATE: begin
							if (head_ok) begin
								nid_q <= 4'(fh_top_q);
								h_q <= HW'(fh_top_q);
								fh_top_q <= hch_q[HW'(fh_top_q)];
								fh_total_q <= fh_total_q - HNW'(1);
							end else begin
								st_q <= ST_EXH;
							end
							state_q <= S_OUT;
						end
						CMD_COUNT: state_q <= S_OUT;
						CMD_FIRST, CMD_LAST: begin
							if (((cmd_q == CMD_FIRST) ? f_q : l_q) >= LNULL) begin
								st_q <= ST_NULL;
								state_q <= S_OUT;
							end else begin
								c_q <= CW'((cmd_q == CMD_FIRST) ? f_q : l_q);
								state_q <= S_ITM;
							end
						end
						CMD_CURRENT: begin
							if (c_q >= POOL) begin
								st_q <= ST_NULL;
								state_q <= S_OUT;
							end else begin
								state_q <= S_ITM;
							end
						end
						CMD_NEXT: begin
							if (n_q == '0) begin
								st_q <= ST_NULL;
								state_q <= S_OUT;
							end else if (c_q == BEYOND || c_q == CW'(l_q)) begin
								c_q <= BEYOND;
								st_q <= ST_NULL;
								state_q <= S_WB;
							end else if (c_q == BEFORE) begin
								if (f_q >= LNULL) begin
									c_q <= BEYOND;
									st_q <= ST_NULL;
									state_q <= S_WB;
								end else begin
									c_q <= CW'(f_q);
									state_q <= S_ITM;
								end
							end else begin
								state_q <= S_MV1;
							end
						end
						CMD_PREV: begin
							if (n_q == '0) begin
								st_q <= ST_NULL;
								state_q <= S_OUT;
							end else if (c_q == BEFORE || c_q == CW'(f_q)) begin
								c_q <= BEFORE;
								st_q <= ST_NULL;
								state_q <= S_WB;
							end else if (c_q == BEYOND) begin
								if (l_q >= LNULL) begin
									c_q <= BEFORE;
									st_q <= ST_NULL;
									state_q <= S_WB;
								end else begin
									c_q <= CW'(l_q);
									state_q <= S_ITM;
								end
							end else begin
								state_q <= S_MV1;
							end
						end
						CMD_ADD, CMD_INSERT, CMD_APPEND, CMD_PREPEND: begin
							if (take_ok) begin
								nn_q <= fn_top_q;
								fn_top_q <= fc_rd;
								fn_total_q <= fn_total_q - LW'(1);
								state_q <= S_LNK;
							end else begin
								st_q <= ST_EXH;
								state_q <= S_OUT;
							end
						end
						CMD_REMOVE: state_q <= S_RM0;
						CMD_TRIM: begin
							if (n_q == '0) begin
								st_q <= ST_NULL;
								state_q <= S_OUT;
							end else begin
								c_q <= (l_q < LNULL) ? CW'(l_q) : BEYOND;
								state_q <= S_RM0;
							end
						end
						CMD_FREE: begin
							c_q <= (f_q < LNULL) ? CW'(f_q) : BEFORE;
							state_q <= S_RM0;
						end
						CMD_CONCAT: state_q <= S_LD2;
						default: begin
							// Search: start at the first node when before the list.
							si_q <= '0;
							if (n_q == '0) begin
								c_q <= BEYOND;
								st_q <= ST_NULL;
								state_q <= S_WB;
							end else begin
								if (c_q == BEFORE) c_q <= (f_q < LNULL) ? CW'(f_q) : BEYOND;
								state_q <= S_SRI;
							end
						end
					endcase
				end
				S_MV1: begin
					if (t_mv >= LNULL) begin
						c_q <= (cmd_q == CMD_NEXT) ? BEYOND : BEFORE;
						st_q <= ST_NULL;
						state_q <= S_WB;
					end else begin
						c_q <= CW'(t_mv);
						state_q <= S_ITM;
					end
				end
				S_ITM: begin
					it_q <= rd_item;
					state_q <= S_WB;
				end
				S_LNK: begin
					unique case (lk_mode)
						LK_EMPTY: begin
							f_q <= nn_q;
							l_q <= nn_q;
						end
						LK_BACK: l_q <= nn_q;
						LK_FRONT: f_q <= nn_q;
						default: o_q <= lk_o;
					endcase
					c_q <= CW'(nn_q);
					if (n_q < LNULL) n_q <= n_q + LW'(1);
					state_q <= (lk_mode == LK_MID) ? S_LNK2 : S_WB;
				end
				S_LNK2: state_q <= S_WB;
				S_RM0: begin
					if (n_q == '0 || c_q >= POOL) begin
						if (cmd_q != CMD_FREE) st_q <= ST_NULL;
						state_q <= S_WB;
					end else begin
						state_q <= S_RM1;
					end
				end
				S_RM1: begin
					if (cmd_q != CMD_FREE) it_q <= rd_item;
					rm_q <= LW'(c_q);
					if (n_q == LW'(1)) begin
						f_q <= LNULL;
						l_q <= LNULL;
						c_q <= BEFORE;
					end else if (c_q == CW'(f_q)) begin
						f_q <= rd_next;
						c_q <= (rd_next < LNULL) ? CW'(rd_next) : BEYOND;
					end else if (c_q == CW'(l_q)) begin
						l_q <= rd_prev;
						c_q <= BEYOND;
					end else begin
						c_q <= (rd_next < LNULL) ? CW'(rd_next) : BEYOND;
					end
					n_q <= n_q - LW'(1);
					state_q <= S_RM2;
				end
				S_RM2: begin
					fn_top_q <= rm_q;
					if (fn_total_q < LNULL) fn_total_q <= fn_total_q + LW'(1);
					if (cmd_q == CMD_FREE) begin
						state_q <= S_RM0;
					end else begin
						if (cmd_q == CMD_TRIM && l_q < LNULL) c_q <= CW'(l_q);
						state_q <= S_WB;
					end
				end
				S_SRI: begin
					if (c_q >= POOL || si_q > CW'(NUM_NODES)) begin
						if (c_q < POOL) c_q <= BEYOND;
						st_q <= ST_NULL;
						state_q <= S_WB;
					end else begin
						state_q <= S_SRC;
					end
				end
				S_SRC: begin
					if (rd_item == val_q) begin
						it_q <= val_q;
						state_q <= S_WB;
					end else begin
						si_q <= si_q + CW'(1);
						if (c_q == CW'(l_q)) c_q <= BEYOND;
						else c_q <= (rd_next < LNULL) ? CW'(rd_next) : BEYOND;
						state_q <= S_SRI;
					end
				end
				S_LD2: begin
					f2_q <= hf_q[hr_idx];
					l2_q <= hl_q[hr_idx];
					n2_q <= hn_q[hr_idx];
					state_q <= S_CAT;
				end
				S_CAT: begin
					if (n2_q != '0) begin
						if (n_q == '0) f_q <= f2_q;
						l_q <= l2_q;
						n_q <= cat_len;
					end
					state_q <= S_WB;
				end
				S_WB: begin
					hf_q[h_q] <= f_q;
					hl_q[h_q] <= l_q;
					hc_q[h_q] <= c_q;
					hn_q[h_q] <= n_q;
					if (cmd_q == CMD_FREE || cmd_q == CMD_CONCAT) state_q <= S_GIVEH;
					else state_q <= S_OUT;
				end
				S_GIVEH: begin
					// Release a head back onto the free head chain.
					hf_q[gh_idx] <= LNULL;
					hl_q[gh_idx] <= LNULL;
					hc_q[gh_idx] <= BEFORE;
					hn_q[gh_idx] <= '0;
					hch_q[gh_idx] <= fh_top_q;
					fh_top_q <= HNW'(gh_idx);
					if (fh_total_q < HPOOL) fh_total_q <= fh_total_q + HNW'(1);
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (res_take) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

### rtl/pooled_doubly_linked_list_engine.sv
// Pooled doubly linked list engine, top level. One command at a time.
// Free runs the remove states RM0, RM1 and RM2 once per node, and search runs SRI and SRC
// once per node visited, both set by the one-read node memory port.
// A new command can be accepted in the cycle after the previous result enters the output register.
// Reset: a clearing pass over all NUM_NODES nodes rebuilds links and free chain, in_stall high.
// Depends on pdll_pkg, pdll_node_mem and pdll_ctrl.
module pooled_doubly_linked_list_engine #(
	parameter int NUM_LISTS = pdll_pkg::DefNumLists,
	parameter int NUM_NODES = pdll_pkg::DefNumNodes,
	parameter int ITEM_WIDTH = pdll_pkg::DefItemWidth
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [3:0]  command,
	input  logic [3:0]  list_id,
	input  logic [3:0]  other_list_id,
	input  logic [31:0] item_value,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [31:0] item_out,
	output logic [8:0]  count_out,
	output logic [3:0]  new_list_id
);
	import pdll_pkg::*;

	localparam int LW = $clog2(NUM_NODES + 1);
	localparam int CW = $clog2(NUM_NODES + 2);

	logic                  res_valid;
	logic                  res_take;
	pdll_result_t          res;
	pdll_result_t          res_q;
	logic                  ov_q;
	logic [CW-1:0]         rd_addr;
	logic [LW-1:0]         rd_next;
	logic [LW-1:0]         rd_prev;
	logic [ITEM_WIDTH-1:0] rd_item;
	logic                  nx_we;
	logic [CW-1:0]         nx_addr;
	logic [LW-1:0]         nx_data;
	logic                  pv_we;
	logic [CW-1:0]         pv_addr;
	logic [LW-1:0]         pv_data;
	logic                  it_we;
	logic [CW-1:0]         it_addr;
	logic [ITEM_WIDTH-1:0] it_data;
	logic [CW-1:0]         fc_raddr;
	logic [LW-1:0]         fc_rd;
	logic                  fc_we;
	logic [CW-1:0]         fc_waddr;
	logic [LW-1:0]         fc_data;

	pdll_ctrl #(
		.NUM_LISTS(NUM_LISTS),
		.NUM_NODES(NUM_NODES),
		.ITEM_WIDTH(ITEM_WIDTH)
	) u_ctrl (
		.clk, .arst_n, .in_valid, .in_stall, .command, .list_id, .other_list_id,
		.item_value, .res_valid, .res_take, .res, .rd_addr, .rd_next, .rd_prev,
		.rd_item, .nx_we, .nx_addr, .nx_data, .pv_we, .pv_addr, .pv_data, .it_we,
		.it_addr, .it_data, .fc_raddr, .fc_rd, .fc_we, .fc_waddr, .fc_data
	);

	pdll_node_mem #(
		.NUM_NODES(NUM_NODES),
		.ITEM_WIDTH(ITEM_WIDTH)
	) u_mem (
		.clk, .rd_addr, .rd_next, .rd_prev, .rd_item, .nx_we, .nx_addr, .nx_data,
		.pv_we, .pv_addr, .pv_data, .it_we, .it_addr, .it_data, .fc_raddr, .fc_rd,
		.fc_we, .fc_waddr, .fc_data
	);

	// Output register: takes a result beat whenever the slot is empty or draining.
	assign res_take = res_valid && (!ov_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (res_take) begin
			ov_q <= 1'b1;
		end else if (!out_stall) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) res_q <= res;
	end

	assign out_valid = ov_q;
	assign status = res_q.status;
	assign item_out = res_q.item;
	assign count_out = res_q.count;
	assign new_list_id = res_q.new_id;

endmodule

### rtl/pdll_checker.sv
// Port-level checks for the pooled doubly linked list engine.
// Depends on pdll_pkg; bound to the top level at the end of this file.
module pdll_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [1:0]  status,
	input logic [31:0] item_out,
	input logic [3:0]  new_list_id
);
	import pdll_pkg::*;

	// A stalled result beat holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(item_out) && $stable(status))
		else $error("result beat changed while stalled");

	// Failed commands never carry an item.
	a_item_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |-> item_out == 32'd0)
		else $error("item on a failed command");

	// An exhausted pool hands out no head.
	a_no_id: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_EXH |-> new_list_id == 4'd0)
		else $error("head id on exhausted status");

	// One command at a time: the input stalls right after an accept.
	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("second command taken while busy");

endmodule

bind pooled_doubly_linked_list_engine pdll_checker u_chk (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(in_valid),
	.in_stall(in_stall),
	.out_valid(out_valid),
	.out_stall(out_stall),
	.status(status),
	.item_out(item_out),
	.new_list_id(new_list_id)
);

### dv/tb.sv
// Self-checking testbench for the pooled doubly linked list engine.
// Depends on rtl/pdll_pkg.sv and the engine RTL. Commands are checked against an in-bench model.
`timescale 1ns / 1ps

module tb;
	import pdll_pkg::*;

	localparam int Lists = DefNumLists;
	localparam int Nodes = DefNumNodes;
	localparam int unsigned NoNode = Nodes;
	localparam int unsigned AtBefore = Nodes;
	localparam int unsigned AtBeyond = Nodes + 1;
	localparam int NumItems = 1500;
	localparam int IdleLimit = 20000;

	typedef struct {
		logic [3:0]   cmd;
		logic [3:0]   lid;
		logic [3:0]   oid;
		logic [31:0]  val;
		bit           drain;
		pdll_result_t want;
	} cmd_beat_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [3:0]  command = '0;
	logic [3:0]  list_id = '0;
	logic [3:0]  other_list_id = '0;
	logic [31:0] item_value = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [1:0]  status;
	logic [31:0] item_out;
	logic [8:0]  count_out;
	logic [3:0]  new_list_id;

	pooled_doubly_linked_list_engine dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.command(command), .list_id(list_id), .other_list_id(other_list_id),
		.item_value(item_value),
		.out_valid(out_valid), .out_stall(out_stall),
		.status(status), .item_out(item_out), .count_out(count_out),
		.new_list_id(new_list_id)
	);

	always #5 clk = ~clk;

	// Mirror of the list engine state.
	int unsigned  link_fwd[Nodes];
	int unsigned  link_back[Nodes];
	logic [31:0]  word_of[Nodes];
	int unsigned  spare_node_link[Nodes];
	int unsigned  spare_node_top, spare_node_cnt;
	int unsigned  head_first[Lists];
	int unsigned  head_last[Lists];
	int unsigned  head_cur[Lists];
	int unsigned  head_len[Lists];
	int unsigned  spare_head_link[Lists];
	int unsigned  spare_head_top, spare_head_cnt;
	bit           live[Lists];

	cmd_beat_t pending_cmds[$];
	cmd_beat_t awaited_results[$];
	cmd_beat_t cur_beat;
	bit        failed = 1'b0;
	int        n_sent = 0, n_got = 0, n_null = 0, n_exh = 0, n_drains = 0;

	function automatic int unsigned fwd_of(int unsigned n);
		return n < Nodes ? link_fwd[n] : NoNode;
	endfunction

	function automatic int unsigned back_of(int unsigned n);
		return n < Nodes ? link_back[n] : NoNode;
	endfunction

	function automatic void set_fwd(int unsigned n, int unsigned v);
		if (n < Nodes) link_fwd[n] = v;
	endfunction

	function automatic void set_back(int unsigned n, int unsigned v);
		if (n < Nodes) link_back[n] = v;
	endfunction

	function automatic void reset_pools();
		for (int i = 0; i < Nodes; i++) begin
			link_fwd[i] = NoNode;
			link_back[i] = NoNode;
			word_of[i] = '0;
			spare_node_link[i] = i + 1;
		end
		for (int i = 0; i < Lists; i++) begin
			head_first[i] = NoNode;
			head_last[i] = NoNode;
			head_cur[i] = AtBefore;
			head_len[i] = 0;
			spare_head_link[i] = i + 1;
			live[i] = 1'b0;
		end
		spare_node_top = 0;
		spare_node_cnt = Nodes;
		spare_head_top = 0;
		spare_head_cnt = Lists;
	endfunction

	function automatic int unsigned grab_node(logic [31:0] v);
		int unsigned n;
		n = spare_node_top;
		if (spare_node_cnt == 0 || n >= Nodes) return NoNode;
		spare_node_top = spare_node_link[n];
		spare_node_cnt--;
		word_of[n] = v;
		link_fwd[n] = NoNode;
		link_back[n] = NoNode;
		return n;
	endfunction

	function automatic void drop_node(int unsigned n);
		if (n >= Nodes) return;
		spare_node_link[n] = spare_node_top;
		spare_node_top = n;
		if (spare_node_cnt < Nodes) spare_node_cnt++;
		link_fwd[n] = NoNode;
		link_back[n] = NoNode;
		word_of[n] = '0;
	endfunction

	function automatic void drop_head(int unsigned h);
		head_first[h] = NoNode;
		head_last[h] = NoNode;
		head_cur[h] = AtBefore;
		head_len[h] = 0;
		spare_head_link[h] = spare_head_top;
		spare_head_top = h;
		if (spare_head_cnt < Lists) spare_head_cnt++;
	endfunction

	function automatic void hook_front(int unsigned h, int unsigned n);
		set_back(head_first[h], n);
		link_fwd[n] = head_first[h];
		head_first[h] = n;
	endfunction

	function automatic void hook_back(int unsigned h, int unsigned n);
		set_fwd(head_last[h], n);
		link_back[n] = head_last[h];
		head_last[h] = n;
	endfunction

	function automatic bit step_fwd(int unsigned h, output logic [31:0] w);
		int unsigned c;
		c = head_cur[h];
		w = '0;
		if (head_len[h] == 0) return 1'b0;
		if (c == AtBeyond || c == head_last[h]) begin
			head_cur[h] = AtBeyond;
			return 1'b0;
		end
		c = (c == AtBefore) ? head_first[h] : fwd_of(c);
		if (c >= Nodes) begin
			head_cur[h] = AtBeyond;
			return 1'b0;
		end
		head_cur[h] = c;
		w = word_of[c];
		return 1'b1;
	endfunction

	function automatic bit step_back(int unsigned h, output logic [31:0] w);
		int unsigned c;
		c = head_cur[h];
		w = '0;
		if (head_len[h] == 0) return 1'b0;
		if (c == AtBefore || c == head_first[h]) begin
			head_cur[h] = AtBefore;
			return 1'b0;
		end
		c = (c == AtBeyond) ? head_last[h] : back_of(c);
		if (c >= Nodes) begin
			head_cur[h] = AtBefore;
			return 1'b0;
		end
		head_cur[h] = c;
		w = word_of[c];
		return 1'b1;
	endfunction

	function automatic bit unlink_cur(int unsigned h, output logic [31:0] w);
		int unsigned c, p, n;
		c = head_cur[h];
		w = '0;
		if (head_len[h] == 0 || c >= Nodes) return 1'b0;
		w = word_of[c];
		if (head_len[h] == 1) begin
			head_first[h] = NoNode;
			head_last[h] = NoNode;
			head_cur[h] = AtBefore;
		end else if (c == head_first[h]) begin
			head_first[h] = fwd_of(c);
			set_back(head_first[h], NoNode);
			head_cur[h] = head_first[h] < Nodes ? head_first[h] : AtBeyond;
		end else if (c == head_last[h]) begin
			head_last[h] = back_of(c);
			set_fwd(head_last[h], NoNode);
			head_cur[h] = AtBeyond;
		end else begin
			p = back_of(c);
			n = fwd_of(c);
			set_fwd(p, n);
			set_back(n, p);
			head_cur[h] = n < Nodes ? n : AtBeyond;
		end
		head_len[h]--;
		drop_node(c);
		return 1'b1;
	endfunction

	// Applies one command to the mirror and returns the result beat it must produce.
	function automatic pdll_result_t run_list_cmd(logic [3:0] cmd, int unsigned h,
			int unsigned h2, logic [31:0] v);
		pdll_result_t r;
		logic [31:0] w, junk;
		int unsigned report, n, c, o, sum, left;
		bit ok, hit;
		w = '0;
		ok = 1'b1;
		report = h;
		r.status = ST_OK;
		r.new_id = '0;
		case (cmd)
			CMD_CREATE: begin
				if (spare_head_cnt == 0 || spare_head_top >= Lists) begin
					r.status = ST_EXH;
				end else begin
					r.new_id = 4'(spare_head_top);
					spare_head_top = spare_head_link[r.new_id];
					spare_head_cnt--;
					report = r.new_id;
				end
			end
			CMD_COUNT: ;
			CMD_FIRST, CMD_LAST: begin
				n = (cmd == CMD_FIRST) ? head_first[h] : head_last[h];
				if (n >= Nodes) ok = 1'b0;
				else begin
					head_cur[h] = n;
					w = word_of[n];
				end
			end
			CMD_NEXT: ok = step_fwd(h, w);
			CMD_PREV: ok = step_back(h, w);
			CMD_CURRENT: begin
				if (head_cur[h] >= Nodes) ok = 1'b0;
				else w = word_of[head_cur[h]];
			end
			CMD_ADD, CMD_INSERT, CMD_APPEND, CMD_PREPEND: begin
				c = head_cur[h];
				n = grab_node(v);
				if (n == NoNode) r.status = ST_EXH;
				else begin
					if (head_len[h] == 0) begin
						head_first[h] = n;
						head_last[h] = n;
					end else if (cmd == CMD_APPEND) hook_back(h, n);
					else if (cmd == CMD_PREPEND) hook_front(h, n);
					else if (cmd == CMD_ADD) begin
						if (c == AtBefore) hook_front(h, n);
						else if (c >= Nodes || c == head_last[h]) hook_back(h, n);
						else begin
							o = link_fwd[c];
							link_fwd[c] = n;
							link_back[n] = c;
							link_fwd[n] = o;
							set_back(o, n);
						end
					end else begin
						if (c == AtBefore || c == head_first[h]) hook_front(h, n);
						else if (c >= Nodes) hook_back(h, n);
						else begin
							o = link_back[c];
							link_back[c] = n;
							link_fwd[n] = c;
							link_back[n] = o;
							set_fwd(o, n);
						end
					end
					head_cur[h] = n;
					if (head_len[h] < Nodes) head_len[h]++;
				end
			end
			CMD_REMOVE: ok = unlink_cur(h, w);
			CMD_CONCAT: begin
				sum = head_len[h] + head_len[h2];
				if (sum > Nodes) sum = Nodes;
				if (head_len[h] > 0 && head_len[h2] > 0) begin
					set_fwd(head_last[h], head_first[h2]);
					set_back(head_first[h2], head_last[h]);
					head_last[h] = head_last[h2];
					head_len[h] = sum;
				end else if (head_len[h2] > 0) begin
					head_first[h] = head_first[h2];
					head_last[h] = head_last[h2];
					head_len[h] = sum;
				end
				drop_head(h2);
			end
			CMD_FREE: begin
				left = head_len[h];
				head_cur[h] = head_first[h] < Nodes ? head_first[h] : AtBefore;
				for (int i = 0; i < left && i < Nodes; i++) void'(unlink_cur(h, junk));
				drop_head(h);
			end
			CMD_TRIM: begin
				if (head_len[h] == 0) ok = 1'b0;
				else begin
					head_cur[h] = head_last[h] < Nodes ? head_last[h] : AtBeyond;
					ok = unlink_cur(h, w);
					if (head_last[h] < Nodes) head_cur[h] = head_last[h];
				end
			end
			default: begin
				// Search walks forward from the cursor, or from the first node when before.
				hit = 1'b0;
				if (head_len[h] == 0) begin
					head_cur[h] = AtBeyond;
					ok = 1'b0;
				end else begin
					if (head_cur[h] == AtBefore)
						head_cur[h] = head_first[h] < Nodes ? head_first[h] : AtBeyond;
					for (int i = 0; i <= Nodes && head_cur[h] < Nodes; i++) begin
						if (word_of[head_cur[h]] == v) begin
							hit = 1'b1;
							w = v;
							break;
						end
						void'(step_fwd(h, junk));
					end
					if (!hit && head_cur[h] < Nodes) head_cur[h] = AtBeyond;
					ok = hit;
				end
			end
		endcase
		if (!ok) begin
			r.status = ST_NULL;
			w = '0;
		end
		r.item = w;
		r.count = 9'(head_len[report]);
		return r;
	endfunction

	// Queues one command and records its expected beat; also tracks which heads are in use.
	function automatic void queue_cmd(logic [3:0] cmd, logic [3:0] h, logic [3:0] h2,
			logic [31:0] v, bit drain);
		cmd_beat_t b;
		b.cmd = cmd;
		b.lid = h;
		b.oid = h2;
		b.val = v;
		b.drain = drain;
		b.want = run_list_cmd(cmd, h, h2, v);
		if (cmd == CMD_CREATE && b.want.status == ST_OK) live[b.want.new_id] = 1'b1;
		if (cmd == CMD_FREE) live[h] = 1'b0;
		if (cmd == CMD_CONCAT) live[h2] = 1'b0;
		pending_cmds.push_back(b);
	endfunction

	function automatic logic [3:0] pick_list();
		int unsigned cand[$];
		for (int i = 0; i < Lists; i++) if (live[i]) cand.push_back(i);
		if (cand.size() == 0 || $urandom_range(0, 19) == 0)
			return 4'($urandom_range(0, Lists - 1));
		return 4'(cand[$urandom_range(0, cand.size() - 1)]);
	endfunction

	function automatic logic [31:0] pick_word();
		return ($urandom_range(0, 2) == 0) ? $urandom : $urandom_range(0, 7);
	endfunction

	// Stimulus: directed corner cases, then biased random traffic that alternates
	// between growing and shrinking the pools.
	initial begin
		int r;
		logic [3:0] h, h2, cmd;
		bit grow;
		reset_pools();
		queue_cmd(CMD_CREATE, 0, 0, 0, 0);
		queue_cmd(CMD_FIRST, 0, 0, 0, 0);
		queue_cmd(CMD_NEXT, 0, 0, 0, 0);
		queue_cmd(CMD_PREV, 0, 0, 0, 0);
		queue_cmd(CMD_CURRENT, 0, 0, 0, 0);
		queue_cmd(CMD_REMOVE, 0, 0, 0, 0);
		queue_cmd(CMD_TRIM, 0, 0, 0, 0);
		queue_cmd(CMD_SEARCH, 0, 0, 32'h0, 0);
		queue_cmd(CMD_APPEND, 0, 0, 32'h0, 0);
		queue_cmd(CMD_PREPEND, 0, 0, 32'hFFFF_FFFF, 0);
		queue_cmd(CMD_ADD, 0, 0, 32'hA5A5_5A5A, 0);
		queue_cmd(CMD_INSERT, 0, 0, 32'h5A5A_A5A5, 0);
		queue_cmd(CMD_LAST, 0, 0, 0, 0);
		queue_cmd(CMD_NEXT, 0, 0, 0, 0);
		queue_cmd(CMD_NEXT, 0, 0, 0, 0);
		queue_cmd(CMD_REMOVE, 0, 0, 0, 0);
		queue_cmd(CMD_FIRST, 0, 0, 0, 0);
		queue_cmd(CMD_PREV, 0, 0, 0, 0);
		queue_cmd(CMD_SEARCH, 0, 0, 32'h0, 0);
		queue_cmd(CMD_SEARCH, 0, 0, 32'h1234_5678, 0);
		queue_cmd(CMD_APPEND, 15, 0, 32'h8000_0001, 0);
		queue_cmd(CMD_CONCAT, 0, 15, 0, 0);
		queue_cmd(CMD_COUNT, 0, 0, 0, 0);
		queue_cmd(CMD_FREE, 0, 0, 0, 0);
		queue_cmd(CMD_COUNT, 15, 0, 0, 1);
		for (int k = 0; k < NumItems; k++) begin
			grow = ((k / 250) % 2) == 0;
			r = $urandom_range(0, 99);
			h = pick_list();
			h2 = pick_list();
			if (grow) begin
				if (r < 8) cmd = CMD_CREATE;
				else if (r < 50) cmd = 4'(CMD_ADD + $urandom_range(0, 3));
				else if (r < 66) cmd = 4'(CMD_FIRST + $urandom_range(0, 4));
				else if (r < 74) cmd = CMD_SEARCH;
				else if (r < 81) cmd = CMD_REMOVE;
				else if (r < 84) cmd = CMD_TRIM;
				else if (r < 88) cmd = CMD_COUNT;
				else if (r < 91) cmd = CMD_CONCAT;
				else if (r < 92) cmd = CMD_FREE;
				else cmd = 4'($urandom_range(0, 15));
			end else begin
				if (r < 6) cmd = CMD_CREATE;
				else if (r < 18) cmd = 4'(CMD_ADD + $urandom_range(0, 3));
				else if (r < 38) cmd = 4'(CMD_FIRST + $urandom_range(0, 4));
				else if (r < 48) cmd = CMD_SEARCH;
				else if (r < 66) cmd = CMD_REMOVE;
				else if (r < 78) cmd = CMD_TRIM;
				else if (r < 82) cmd = CMD_CONCAT;
				else if (r < 88) cmd = CMD_FREE;
				else if (r < 92) cmd = CMD_COUNT;
				else cmd = 4'($urandom_range(0, 15));
			end
			// Keep self-joins rare: they leak nodes for the rest of the run.
			if (cmd == CMD_CONCAT && h == h2 && $urandom_range(0, 9) != 0) cmd = CMD_COUNT;
			queue_cmd(cmd, h, h2, pick_word(), (k % 400) == 399);
		end
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Sender: bursts of beats with random gaps; a drain beat waits for all results.
	int burst_left = 0, gap_left = 0;
	always @(posedge clk) begin
		bit slot_free;
		if (arst_n) begin
			slot_free = !in_valid;
			if (in_valid && !in_stall) begin
				awaited_results.push_back(cur_beat);
				n_sent++;
				slot_free = 1'b1;
			end
			if (slot_free) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (pending_cmds.size() > 0 &&
						(!pending_cmds[0].drain || awaited_results.size() == 0)) begin
					cur_beat = pending_cmds.pop_front();
					if (cur_beat.drain) n_drains++;
					command <= cur_beat.cmd;
					list_id <= cur_beat.lid;
					other_list_id <= cur_beat.oid;
					item_value <= cur_beat.val;
					in_valid <= 1'b1;
					if (burst_left > 0) burst_left--;
					else begin
						burst_left = $urandom_range(0, 30);
						gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 6);
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: stall pattern switches between none, light and heavy every so often.
	int stall_mode = 0, stall_span = 0;
	always @(posedge clk) begin
		cmd_beat_t b;
		if (stall_span == 0) begin
			stall_mode = $urandom_range(0, 2);
			stall_span = $urandom_range(50, 300);
		end else stall_span--;
		case (stall_mode)
			0: out_stall <= 1'b0;
			1: out_stall <= ($urandom_range(0, 9) < 3);
			default: out_stall <= ($urandom_range(0, 9) < 7);
		endcase
		if (arst_n && out_valid && !out_stall) begin
			n_got++;
			if (awaited_results.size() == 0) begin
				$error("result beat with nothing outstanding");
				failed = 1'b1;
			end else begin
				b = awaited_results.pop_front();
				if (status == ST_NULL) n_null++;
				if (status == ST_EXH) n_exh++;
				if (status !== b.want.status) begin
					$error("status: expected %0d, got %0d", b.want.status, status);
					failed = 1'b1;
				end
				if (item_out !== b.want.item) begin
					$error("item_out: expected %h, got %h", b.want.item, item_out);
					failed = 1'b1;
				end
				if (count_out !== b.want.count) begin
					$error("count_out: expected %0d, got %0d", b.want.count, count_out);
					failed = 1'b1;
				end
				if (new_list_id !== b.want.new_id) begin
					$error("new_list_id: expected %0d, got %0d", b.want.new_id, new_list_id);
					failed = 1'b1;
				end
			end
		end
	end

	// Watchdog: ends the run when neither side moves for too long.
	int idle_cycles = 0;
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IdleLimit) begin
			$display("watchdog expired after %0d sent, %0d received", n_sent, n_got);
			$display("pooled_doubly_linked_list_engine regression: fail");
			$finish;
		end
	end

	// End of test: all commands sent and every result back, then a short settle.
	initial begin
		wait (arst_n);
		wait (pending_cmds.size() == 0 && !in_valid && awaited_results.size() == 0);
		repeat (50) @(posedge clk);
		if (awaited_results.size() != 0) failed = 1'b1;
		$display("sent %0d commands, checked %0d results (%0d null, %0d exhausted)",
			n_sent, n_got, n_null, n_exh);
		$display("drain pauses taken: %0d", n_drains);
		if (!failed) $display("pooled_doubly_linked_list_engine regression: pass");
		else $display("pooled_doubly_linked_list_engine regression: fail");
		$finish;
	end

endmodule
